/* rtl/hla_pkg.sv */
`timescale 1ns / 1ps

package hla_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 32;
   localparam int LABEL_ENTRIES = 256;
   localparam int LABEL_INDEX_BITS = $clog2(LABEL_ENTRIES);
   localparam int QUEUE_DEPTH = 4;
   localparam int RESULT_BITS = 32;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_FIRST = 2'd1;
   localparam logic [1:0] CMD_SECOND = 2'd2;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_COMMENT = 2'd1;
   localparam logic [1:0] MODE_LABEL = 2'd2;
   localparam logic [1:0] MODE_POINTER = 2'd3;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_LABEL = 2'd1;
   localparam logic [1:0] KIND_POINTER = 2'd2;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_HASH = 8'd35;
   localparam logic [7:0] CHAR_PERCENT = 8'd37;
   localparam logic [7:0] CHAR_COLON = 8'd58;
   localparam logic [7:0] CHAR_SEMICOLON = 8'd59;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_F = 8'd70;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_F = 8'd102;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
   } hla_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } hla_rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } hla_job_type;

   // msb flags a hex digit, low four bits carry its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      begin
         v = '0;
         ok = 1'b0;
         if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c - CHAR_DIGIT_0;
            ok = 1'b1;
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            v = c - LOWER_OFFSET;
            ok = 1'b1;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = c - UPPER_OFFSET;
            ok = 1'b1;
         end
         return {ok, v[3:0]};
      end
   endfunction

endpackage

/* rtl/hla_fifo.sv */
`timescale 1ns / 1ps

module hla_fifo import hla_pkg::*; #(
   parameter int WIDTH = $bits(hla_job_type) + ADDRESS_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign full = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/hla_front.sv */
`timescale 1ns / 1ps

module hla_front import hla_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hla_req_type             req_data,
   input  logic                    queue_full,
   output logic                    push,
   output hla_job_type             push_job,
   output logic [ADDRESS_BITS-1:0] push_pos
);

   logic [1:0]              mode_ff, mode_in;
   logic                    pending_ff, pending_in;
   logic [3:0]              held_ff, held_in;
   logic [ADDRESS_BITS-1:0] pos_ff, pos_in;
   logic                    accept;
   logic                    emit;
   logic [4:0]              digit;
   logic [7:0]              c;

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign c = req_data.char_code;
   assign emit = (req_data.command == CMD_SECOND);
   assign digit = hex_digit(c);
   assign push_pos = pos_ff;

   always_comb begin
      mode_in = mode_ff;
      pending_in = pending_ff;
      held_in = held_ff;
      pos_in = pos_ff;
      push = 1'b0;
      push_job = '{kind: KIND_BYTE, data: c};
      if (accept) begin
         case (req_data.command)
            CMD_RESTART: begin
               mode_in = MODE_NORMAL;
               pending_in = 1'b0;
               held_in = '0;
               pos_in = '0;
            end
            CMD_FIRST, CMD_SECOND: begin
               case (mode_ff)
                  MODE_COMMENT: begin
                     if (c == CHAR_LF || c == CHAR_CR) begin
                        mode_in = MODE_NORMAL;
                     end
                  end
                  MODE_LABEL: begin
                     if (!emit) begin
                        push = 1'b1;
                        push_job.kind = KIND_LABEL;
                     end
                     mode_in = MODE_NORMAL;
                  end
                  MODE_POINTER: begin
                     if (emit) begin
                        push = 1'b1;
                        push_job.kind = KIND_POINTER;
                     end
                     mode_in = MODE_NORMAL;
                  end
                  default: begin
                     if (c == CHAR_COLON) begin
                        mode_in = MODE_LABEL;
                     end else if (c == CHAR_PERCENT) begin
                        pos_in = pos_ff + ADDRESS_BITS'(4);
                        mode_in = MODE_POINTER;
                     end else if (c == CHAR_HASH || c == CHAR_SEMICOLON) begin
                        mode_in = MODE_COMMENT;
                     end else if (digit[4]) begin
                        if (pending_ff) begin
                           if (emit) begin
                              push = 1'b1;
                              push_job.data = {held_ff, digit[3:0]};
                           end
                           pos_in = pos_ff + ADDRESS_BITS'(1);
                           held_in = '0;
                           pending_in = 1'b0;
                        end else begin
                           held_in = digit[3:0];
                           pending_in = 1'b1;
                        end
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         pending_ff <= 1'b0;
         held_ff <= '0;
         pos_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pending_ff <= pending_in;
         held_ff <= held_in;
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/hla_back.sv */
`timescale 1ns / 1ps

module hla_back import hla_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   output logic                    queue_pop,
   input  hla_job_type             head_job,
   input  logic [ADDRESS_BITS-1:0] head_pos,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hla_rsp_type             rsp_data
);

   localparam logic [1:0] BACK_IDLE = 2'd0;
   localparam logic [1:0] BACK_LOAD = 2'd1;
   localparam logic [1:0] BACK_SEND = 2'd2;

   logic [ADDRESS_BITS-1:0]        label_mem_ff [LABEL_ENTRIES];
   logic [LABEL_ENTRIES-1:0]       valid_ff;
   logic [ADDRESS_BITS-1:0]        rd_data_ff;
   logic                           rd_hit_ff;
   logic [1:0]                     state_ff, state_in;
   logic [1:0]                     cnt_ff, cnt_in;
   logic [RESULT_BITS-1:0]         diff_ff, diff_in;
   logic [ADDRESS_BITS-1:0]        ptr_pos_ff, ptr_pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   hla_rsp_type                    rsp_data_ff, rsp_data_in;
   logic                           out_free;
   logic                           wr_en;
   logic                           rd_en;
   logic [LABEL_INDEX_BITS-1:0]    idx;
   logic [ADDRESS_BITS-1:0]        rd_value;
   logic signed [ADDRESS_BITS-1:0] delta;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx = head_job.data;
   assign rd_value = rd_hit_ff ? rd_data_ff : '0;
   assign delta = rd_value - ptr_pos_ff;

   always_comb begin
      queue_pop = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;
      state_in = state_ff;
      cnt_in = cnt_ff;
      diff_in = diff_ff;
      ptr_pos_in = ptr_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               case (head_job.kind)
                  KIND_BYTE: begin
                     if (out_free) begin
                        queue_pop = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in = '{out_byte: head_job.data, last_of_run: 1'b1};
                     end
                  end
                  KIND_LABEL: begin
                     queue_pop = 1'b1;
                     wr_en = 1'b1;
                  end
                  KIND_POINTER: begin
                     queue_pop = 1'b1;
                     rd_en = 1'b1;
                     ptr_pos_in = head_pos;
                     state_in = BACK_LOAD;
                  end
                  default: begin
                     queue_pop = 1'b1;
                  end
               endcase
            end
         end
         BACK_LOAD: begin
            // label address minus advanced position, sign-extended
            diff_in = RESULT_BITS'(delta);
            cnt_in = '0;
            state_in = BACK_SEND;
         end
         BACK_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{out_byte: diff_ff[{cnt_ff, 3'b000} +: 8],
                               last_of_run: (cnt_ff == 2'd3)};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 2'd3) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      ptr_pos_ff <= ptr_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         label_mem_ff[idx] <= head_pos;
      end
      if (rd_en) begin
         rd_data_ff <= label_mem_ff[idx];
         rd_hit_ff <= valid_ff[idx];
      end
   end

endmodule

/* rtl/hex_label_assembler_top.sv */
`timescale 1ns / 1ps
// one character per cycle unless req_stall; a data byte is queued, then registered onto rsp
// a pointer's four bytes pass the result stage as table read, subtract, four sends
// the front keeps accepting while the queue of four entries has room
// synchronous reset clears parse state, position, queue and the label valid bits
// labels never written read as zero; no clearing pass is needed after reset

module hex_label_assembler_top import hla_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hla_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hla_rsp_type rsp_data
);

   localparam int QUEUE_WIDTH = $bits(hla_job_type) + ADDRESS_BITS;

   logic                    push;
   hla_job_type             push_job;
   logic [ADDRESS_BITS-1:0] push_pos;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    queue_pop;
   logic [QUEUE_WIDTH-1:0]  head_data;
   hla_job_type             head_job;
   logic [ADDRESS_BITS-1:0] head_pos;

   assign head_job = head_data[QUEUE_WIDTH-1 -: $bits(hla_job_type)];
   assign head_pos = head_data[ADDRESS_BITS-1:0];

   hla_front #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .queue_full(queue_full),
      .push(push),
      .push_job(push_job),
      .push_pos(push_pos)
   );

   hla_fifo #(
      .WIDTH(QUEUE_WIDTH)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({push_job, push_pos}),
      .full(queue_full),
      .pop(queue_pop),
      .empty(queue_empty),
      .head_data(head_data)
   );

   hla_back #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .queue_pop(queue_pop),
      .head_job(head_job),
      .head_pos(head_pos),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

/* dv/hla_checker.sv */
`timescale 1ns / 1ps

module hla_checker import hla_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  hla_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  hla_rsp_type rsp_data,
   output int unsigned bytes_owed,
   output int unsigned failures
);

   logic [ADDRESS_BITS-1:0] label_addr [LABEL_ENTRIES];
   logic [ADDRESS_BITS-1:0] position;
   logic                    nibble_held;
   logic [3:0]              high_nibble;
   logic [1:0]              parse_mode;
   hla_rsp_type             code_bytes [$];
   hla_rsp_type             want;

   task automatic assemble(input hla_req_type item);
      logic                           emit;
      logic                           is_digit;
      logic [3:0]                     digit;
      logic [7:0]                     folded;
      logic signed [ADDRESS_BITS-1:0] offset;
      logic [31:0]                    offset_word;
      emit = (item.command == CMD_SECOND);
      if (item.command == CMD_RESTART) begin
         position = '0;
         nibble_held = 1'b0;
         high_nibble = '0;
         parse_mode = MODE_NORMAL;
      end else if (item.command == CMD_FIRST || emit) begin
         case (parse_mode)
            MODE_COMMENT: begin
               if (item.char_code == CHAR_LF || item.char_code == CHAR_CR)
                  parse_mode = MODE_NORMAL;
            end
            MODE_LABEL: begin
               if (!emit)
                  label_addr[item.char_code] = position;
               parse_mode = MODE_NORMAL;
            end
            MODE_POINTER: begin
               if (emit) begin
                  offset = label_addr[item.char_code] - position;
                  offset_word = 32'(offset);
                  for (int k = 0; k < 4; k++)
                     code_bytes.push_back('{out_byte: offset_word[8*k +: 8],
                                            last_of_run: (k == 3)});
               end
               parse_mode = MODE_NORMAL;
            end
            default: begin
               if (item.char_code == CHAR_COLON) begin
                  parse_mode = MODE_LABEL;
               end else if (item.char_code == CHAR_PERCENT) begin
                  position = position + ADDRESS_BITS'(4);
                  parse_mode = MODE_POINTER;
               end else if (item.char_code == CHAR_HASH ||
                            item.char_code == CHAR_SEMICOLON) begin
                  parse_mode = MODE_COMMENT;
               end else begin
                  // letters fold to lower case by setting bit 5
                  folded = item.char_code | 8'h20;
                  is_digit = 1'b1;
                  digit = '0;
                  if (item.char_code >= CHAR_DIGIT_0 && item.char_code <= CHAR_DIGIT_9)
                     digit = 4'(item.char_code - CHAR_DIGIT_0);
                  else if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_F)
                     digit = 4'(folded - LOWER_OFFSET);
                  else
                     is_digit = 1'b0;
                  if (is_digit) begin
                     if (nibble_held) begin
                        if (emit)
                           code_bytes.push_back('{out_byte: {high_nibble, digit},
                                                  last_of_run: 1'b1});
                        position = position + ADDRESS_BITS'(1);
                        high_nibble = '0;
                        nibble_held = 1'b0;
                     end else begin
                        high_nibble = digit;
                        nibble_held = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (label_addr[i])
            label_addr[i] = '0;
         position = '0;
         nibble_held = 1'b0;
         high_nibble = '0;
         parse_mode = MODE_NORMAL;
         code_bytes.delete();
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (code_bytes.size() == 0) begin
               $display("%0t: byte %h last %b arrived with nothing expected",
                        $time, rsp_data.out_byte, rsp_data.last_of_run);
               failures++;
            end else begin
               want = code_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h, got %h",
                           $time, want.out_byte, rsp_data.out_byte);
                  failures++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run expected %b, got %b",
                           $time, want.last_of_run, rsp_data.last_of_run);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall)
            assemble(req_data);
      end
      bytes_owed <= code_bytes.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import hla_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STALE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   hla_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   hla_rsp_type rsp_data;

   int unsigned bytes_owed;
   int unsigned failures;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          hold_req;
   int unsigned hold_left;
   int unsigned stale_cycles;

   hex_label_assembler_top i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   hla_checker i_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .bytes_owed,
      .failures
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      stale_cycles = 0;
      while (stale_cycles < STALE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stale_cycles = 0;
         else
            stale_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send(input logic [1:0] command, input logic [7:0] char_code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: command, char_code: char_code};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char();
      int unsigned v;
      v = $urandom_range(15);
      if (v < 10)
         return 8'(CHAR_DIGIT_0 + v);
      else if ($urandom_range(1))
         return 8'(CHAR_LOWER_A + v - 10);
      else
         return 8'(CHAR_UPPER_A + v - 10);
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] pool [4];
      pool = '{"x", "y", "z", CHAR_PERCENT};
      if ($urandom_range(3) == 0)
         return 8'($urandom_range(255));
      return pool[$urandom_range(3)];
   endfunction

   // same source text through both passes, optionally with a long output hold-off
   task automatic run_program(input int unsigned token_count, input bit hold_output);
      logic [7:0] text [$];
      for (int t = 0; t < token_count; t++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               text.push_back(hex_char());
               text.push_back(hex_char());
            end
            4: begin
               text.push_back(CHAR_COLON);
               text.push_back(name_char());
            end
            5, 6: begin
               text.push_back(CHAR_PERCENT);
               text.push_back(name_char());
            end
            7: begin
               text.push_back($urandom_range(1) ? CHAR_HASH : CHAR_SEMICOLON);
               repeat ($urandom_range(3))
                  text.push_back(8'($urandom_range(255)));
               text.push_back($urandom_range(1) ? CHAR_LF : CHAR_CR);
            end
            8: text.push_back(hex_char());
            default: text.push_back(8'($urandom_range(255)));
         endcase
      end
      send(CMD_RESTART, 8'($urandom_range(255)));
      foreach (text[i])
         send(CMD_FIRST, text[i]);
      if (hold_output)
         hold_req = 1'b1;
      send(CMD_RESTART, 8'($urandom_range(255)));
      foreach (text[i])
         send(CMD_SECOND, text[i]);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b0;
      hold_left = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // pointer to a label never recorded
      send(CMD_SECOND, CHAR_PERCENT);
      send(CMD_SECOND, "q");
      send(CMD_RESTART, 8'hff);
      send(CMD_FIRST, CHAR_COLON);
      send(CMD_FIRST, "a");
      send(CMD_FIRST, "F");
      send(CMD_FIRST, "f");
      // repeated label overwrites
      send(CMD_FIRST, CHAR_COLON);
      send(CMD_FIRST, "a");
      send(CMD_FIRST, CHAR_HASH);
      send(CMD_FIRST, CHAR_PERCENT);
      send(CMD_FIRST, CHAR_LF);
      send(CMD_FIRST, CHAR_PERCENT);
      send(CMD_FIRST, "a");
      send(CMD_FIRST, 8'h00);
      send(CMD_FIRST, 8'hff);
      send(CMD_FIRST, CHAR_SEMICOLON);
      send(CMD_FIRST, CHAR_CR);
      send(CMD_UNUSED, CHAR_COLON);
      send(CMD_RESTART, 8'h00);
      send(CMD_SECOND, "F");
      send(CMD_SECOND, "f");
      send(CMD_SECOND, CHAR_COLON);
      send(CMD_SECOND, "a");
      send(CMD_SECOND, CHAR_PERCENT);
      send(CMD_SECOND, "a");
      // mixed passes, markers between the nibbles of one byte
      send(CMD_SECOND, "1");
      send(CMD_FIRST, CHAR_COLON);
      send(CMD_SECOND, "z");
      send(CMD_SECOND, "0");

      // long output hold-off under a run of second-pass bytes
      hold_req = 1'b1;
      repeat (16)
         send(CMD_SECOND, hex_char());

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 17;
               recv_stall_pct = 17;
            end
         endcase
         run_program(5, phase == 0);
         repeat (4)
            send(2'($urandom_range(3)), 8'($urandom_range(255)));
      end

      req_valid <= 1'b0;
      while (bytes_owed != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
rtl/hla_pkg.sv
rtl/hla_fifo.sv
rtl/hla_front.sv
rtl/hla_back.sv
rtl/hex_label_assembler_top.sv
dv/hla_checker.sv
dv/testbench.sv
